>>> rtl/core/imu_fp_pkg.sv
package imu_fp_pkg;

    // frame layout
    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;
    localparam logic [3:0] CHECK_POS  = 4'd10;
    localparam int         AXES       = 3;

    // full scale per kind, raw full scale is 2^RAW_SHIFT
    localparam int FS_W           = 12;
    localparam logic signed [FS_W-1:0] FS_ACCEL = 12'sd16;
    localparam logic signed [FS_W-1:0] FS_RATE  = 12'sd2000;
    localparam logic signed [FS_W-1:0] FS_ANGLE = 12'sd180;
    localparam logic signed [FS_W-1:0] FS_NONE  = 12'sd0;
    localparam int RAW_W          = 16;
    localparam int RAW_SHIFT      = 15;

    // output fixed point format
    localparam int OUT_FRAC_BITS  = 8;
    localparam int OUT_W          = 20;
    localparam int PROD_W         = RAW_W + FS_W + OUT_FRAC_BITS;

    typedef enum logic [1:0] {
        KIND_ACCEL   = 2'd0,
        KIND_RATE    = 2'd1,
        KIND_ANGLE   = 2'd2,
        KIND_UNKNOWN = 2'd3
    } kind_t;

    typedef logic signed [RAW_W-1:0] raw_t;
    typedef logic signed [OUT_W-1:0] value_t;

endpackage

>>> rtl/core/imu_frame_parser.sv
// channel   | direction | ports                                     | width
// ----------+-----------+-------------------------------------------+----------------------
// serial in | in        | s_valid s_ready s_in_byte                 | 8
// result    | out       | m_valid m_ready m_frame_type m_kind_code  | 8, 2
//           |           | m_value_x m_value_y m_value_z             | 20 each, signed
//           |           | m_frame_number                            | 32
//
// one byte is taken every cycle unless a stalled result holds a checksum byte;
// a frame costs 11 byte requests, and the result is registered and shows in the cycle after its checksum byte is taken
// the scaling (three small constant multiplies, a shift and a saturation) sits between
// the stored frame bytes and the result register
// synchronous active low reset puts the parser in header hunt, clears the
// running sum, the frame count and the result valid
// a stalled result blocks only a checksum byte; all other bytes keep flowing
module imu_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_type,
    output logic [1:0]  m_kind_code,
    output logic signed [imu_fp_pkg::OUT_W-1:0] m_value_x,
    output logic signed [imu_fp_pkg::OUT_W-1:0] m_value_y,
    output logic signed [imu_fp_pkg::OUT_W-1:0] m_value_z,
    output logic [31:0] m_frame_number
);

    // parser control state
    logic        in_frame_reg, in_frame_next;
    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] count_reg, count_next;

    // stored frame bytes: type and the six data bytes (bytes 0, 8, 9 only feed the sum)
    logic [7:0]  type_reg;
    logic [7:0]  data_reg [0:5];

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  res_type_reg;
    imu_fp_pkg::kind_t  res_kind_reg;
    imu_fp_pkg::value_t res_val_reg [0:imu_fp_pkg::AXES-1];
    logic [31:0] res_count_reg;

    logic        take;
    logic        at_check;
    logic        frame_ok;
    imu_fp_pkg::kind_t kind;
    logic signed [imu_fp_pkg::FS_W-1:0] fs;
    imu_fp_pkg::value_t scaled [0:imu_fp_pkg::AXES-1];

    // scale one raw axis: floor(raw * fs * 2^frac / 2^15), saturated
    function automatic imu_fp_pkg::value_t scale_axis(
        input imu_fp_pkg::raw_t                    raw,
        input logic signed [imu_fp_pkg::FS_W-1:0] fsv
    );
        logic signed [imu_fp_pkg::RAW_W+imu_fp_pkg::FS_W-1:0] m;
        logic signed [imu_fp_pkg::PROD_W-1:0] p;
        logic signed [imu_fp_pkg::PROD_W-1:0] q;
        logic                                 fits;
        m = raw * fsv;
        p = imu_fp_pkg::PROD_W'(m) <<< imu_fp_pkg::OUT_FRAC_BITS;
        q = p >>> imu_fp_pkg::RAW_SHIFT;
        fits = (q[imu_fp_pkg::PROD_W-1:imu_fp_pkg::OUT_W-1] == '0)
            || (q[imu_fp_pkg::PROD_W-1:imu_fp_pkg::OUT_W-1] == '1);
        if (fits) begin
            scale_axis = q[imu_fp_pkg::OUT_W-1:0];
        end else if (q[imu_fp_pkg::PROD_W-1]) begin
            scale_axis = {1'b1, {(imu_fp_pkg::OUT_W-1){1'b0}}};
        end else begin
            scale_axis = {1'b0, {(imu_fp_pkg::OUT_W-1){1'b1}}};
        end
    endfunction

    // a checksum byte is the only one that can make a result
    assign at_check = in_frame_reg && (pos_reg >= imu_fp_pkg::CHECK_POS);
    assign s_ready  = !(at_check && m_valid_reg && !m_ready);
    assign take     = s_valid && s_ready;
    assign frame_ok = take && at_check && (sum_reg == s_in_byte);

    // type decode
    always_comb begin
        priority if (type_reg == imu_fp_pkg::TYPE_ACCEL) begin
            kind = imu_fp_pkg::KIND_ACCEL;
            fs   = imu_fp_pkg::FS_ACCEL;
        end else if (type_reg == imu_fp_pkg::TYPE_RATE) begin
            kind = imu_fp_pkg::KIND_RATE;
            fs   = imu_fp_pkg::FS_RATE;
        end else if (type_reg == imu_fp_pkg::TYPE_ANGLE) begin
            kind = imu_fp_pkg::KIND_ANGLE;
            fs   = imu_fp_pkg::FS_ANGLE;
        end else begin
            kind = imu_fp_pkg::KIND_UNKNOWN;
            fs   = imu_fp_pkg::FS_NONE;
        end
    end

    // little endian axes from data bytes
    always_comb begin
        for (int a = 0; a < imu_fp_pkg::AXES; a++) begin
            scaled[a] = scale_axis({data_reg[2*a+1], data_reg[2*a]}, fs);
        end
    end

    // parser next state
    always_comb begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        if (take) begin
            if (!in_frame_reg) begin
                if (s_in_byte == imu_fp_pkg::HDR_BYTE) begin
                    in_frame_next = 1'b1;
                    pos_next      = 4'd1;
                    sum_next      = s_in_byte;
                end
            end else if (!at_check) begin
                pos_next = pos_reg + 4'd1;
                sum_next = sum_reg + s_in_byte;
            end else begin
                // checksum byte, good or bad: back to hunting
                in_frame_next = 1'b0;
                pos_next      = 4'd0;
                sum_next      = 8'd0;
                if (frame_ok) begin
                    count_next = count_reg + 32'd1;
                end
            end
        end
    end

    // result valid: a new result only loads when the old one is gone or leaving
    always_comb begin
        if (frame_ok) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            pos_reg      <= 4'd0;
            sum_reg      <= 8'd0;
            count_reg    <= 32'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // frame byte capture by position
    always_ff @(posedge aclk) begin
        if (take && in_frame_reg && !at_check) begin
            if (pos_reg == 4'd1) begin
                type_reg <= s_in_byte;
            end
            for (int i = 0; i < 6; i++) begin
                if (pos_reg == 4'(i + 2)) begin
                    data_reg[i] <= s_in_byte;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (frame_ok) begin
            res_type_reg  <= type_reg;
            res_kind_reg  <= kind;
            res_count_reg <= count_next;
            for (int a = 0; a < imu_fp_pkg::AXES; a++) begin
                res_val_reg[a] <= scaled[a];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_frame_type   = res_type_reg;
    assign m_kind_code    = res_kind_reg;
    assign m_value_x      = res_val_reg[0];
    assign m_value_y      = res_val_reg[1];
    assign m_value_z      = res_val_reg[2];
    assign m_frame_number = res_count_reg;

`ifndef SYNTHESIS
    // a result appears only after a checksum byte is taken
    a_rise_after_check: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(take && at_check))
        else $error("result valid without checksum byte");

    // position stays within the frame
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg <= imu_fp_pkg::CHECK_POS) && (in_frame_reg || (pos_reg == 4'd0)))
        else $error("byte position out of range");

    // the frame count moves only together with a fresh result
    a_count_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> (m_valid_reg && (res_count_reg == count_reg)))
        else $error("frame count changed without result");

    // a pending result is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !frame_ok)
        else $error("result overwritten while stalled");
`endif

endmodule

>>> verif/tb_imu_frame_parser.sv
module tb_imu_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import imu_fp_pkg::*;

    // full scale of each sensor kind, raw full scale is 2^15
    localparam longint ACCEL_RANGE_G   = 16;
    localparam longint RATE_RANGE_DPS  = 2000;
    localparam longint ANGLE_RANGE_DEG = 180;
    localparam int     RAW_FULL_BITS   = 15;
    localparam longint VALUE_MAX       = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint VALUE_MIN       = -(longint'(1) << (OUT_W - 1));

    localparam int FRAME_LEN      = 11;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int DRAIN_CYCLES   = 20;
    // well above the long receiver hold-off, the slowest quiet stretch of a good run
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_PRINTED    = 40;

    typedef struct packed {
        logic [7:0]  frame_type;
        kind_t       kind;
        value_t      x;
        value_t      y;
        value_t      z;
        logic [31:0] frame_number;
    } imu_sample_t;

    // dut ports, all inputs known from time zero
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_frame_type;
    logic [1:0]  m_kind_code;
    value_t      m_value_x;
    value_t      m_value_y;
    value_t      m_value_z;
    logic [31:0] m_frame_number;

    // stimulus control, written by the sequencer with nonblocking assignments
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    logic [7:0]  bytes_to_send[$];
    imu_sample_t samples_due[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;

    // parser shadow state
    logic        hunting = 1'b1;
    logic [3:0]  frame_pos = 4'd0;
    logic [7:0]  frame_sum = 8'd0;
    logic [7:0]  frame_store[10];
    logic [31:0] frames_seen = 32'd0;

    imu_frame_parser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_type   (m_frame_type),
        .m_kind_code    (m_kind_code),
        .m_value_x      (m_value_x),
        .m_value_y      (m_value_y),
        .m_value_z      (m_value_z),
        .m_frame_number (m_frame_number)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // raw * full scale * 2^frac / 2^15, floored, then clamped to the output width
    function automatic value_t scale_axis(raw_t raw, longint range);
        longint prod;
        longint q;
        prod = longint'(raw) * range * (longint'(1) << OUT_FRAC_BITS);
        q = prod >>> RAW_FULL_BITS;
        if (q > VALUE_MAX) q = VALUE_MAX;
        if (q < VALUE_MIN) q = VALUE_MIN;
        return value_t'(q);
    endfunction

    function automatic raw_t stored_axis(int lo);
        return raw_t'({frame_store[lo + 1], frame_store[lo]});
    endfunction

    // advance the shadow parser by one accepted byte, queue a sample on a good frame
    task automatic take_serial_byte(input logic [7:0] b);
        imu_sample_t s;
        longint range;
        if (hunting) begin
            // anything but a header is dropped while hunting
            if (b == HDR_BYTE) begin
                frame_store[0] = b;
                frame_sum = b;
                frame_pos = 4'd1;
                hunting = 1'b0;
            end
        end else if (frame_pos < CHECK_POS) begin
            // header bytes inside a frame are plain data, no resync
            frame_store[frame_pos] = b;
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 4'd1;
        end else begin
            hunting = 1'b1;
            frame_pos = 4'd0;
            if (frame_sum == b) begin
                s.frame_type = frame_store[1];
                case (frame_store[1])
                    TYPE_ACCEL: begin s.kind = KIND_ACCEL; range = ACCEL_RANGE_G; end
                    TYPE_RATE:  begin s.kind = KIND_RATE;  range = RATE_RANGE_DPS; end
                    TYPE_ANGLE: begin s.kind = KIND_ANGLE; range = ANGLE_RANGE_DEG; end
                    default:    begin s.kind = KIND_UNKNOWN; range = 0; end
                endcase
                frames_seen = frames_seen + 32'd1;
                s.x = scale_axis(stored_axis(2), range);
                s.y = scale_axis(stored_axis(4), range);
                s.z = scale_axis(stored_axis(6), range);
                s.frame_number = frames_seen;
                samples_due.push_back(s);
            end
            // a bad checksum drops the frame silently
            frame_sum = 8'd0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // serial byte driver, pulls from the pending byte queue
    always @(posedge aclk) begin : serial_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) take_serial_byte(s_in_byte);
            if (!s_valid || s_ready) begin
                if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_in_byte <= bytes_to_send.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result sink with random stalls and an optional long hold-off
    always @(posedge aclk) begin : result_sink
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker, in order against the shadow parser
    always @(posedge aclk) begin : result_check
        imu_sample_t e;
        if (aresetn && m_valid && m_ready) begin
            if (samples_due.size() == 0) begin
                report_mismatch("unexpected result, frame_number", m_frame_number, 0);
            end else begin
                e = samples_due.pop_front();
                if (m_frame_type !== e.frame_type)
                    report_mismatch("frame_type", m_frame_type, e.frame_type);
                if (m_kind_code !== e.kind)
                    report_mismatch("kind_code", m_kind_code, e.kind);
                if (m_value_x !== e.x)
                    report_mismatch("value_x", m_value_x, e.x);
                if (m_value_y !== e.y)
                    report_mismatch("value_y", m_value_y, e.y);
                if (m_value_z !== e.z)
                    report_mismatch("value_z", m_value_z, e.z);
                if (m_frame_number !== e.frame_number)
                    report_mismatch("frame_number", m_frame_number, e.frame_number);
            end
        end
    end

    // watchdog: cycles with work outstanding but no request moving on either side
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (bytes_to_send.size() == 0 && !s_valid && samples_due.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("tb_imu_frame_parser NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // queue one full frame, checksum right unless corrupted
    task automatic push_frame(input logic [7:0] ftype, input logic [15:0] ax,
                              input logic [15:0] ay, input logic [15:0] az,
                              input bit bad_sum);
        logic [7:0] fr[FRAME_LEN];
        logic [7:0] sum;
        fr[0] = HDR_BYTE;
        fr[1] = ftype;
        {fr[3], fr[2]} = ax;
        {fr[5], fr[4]} = ay;
        {fr[7], fr[6]} = az;
        fr[8] = 8'($urandom_range(255));
        fr[9] = 8'($urandom_range(255));
        sum = 8'd0;
        for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + fr[i];
        fr[10] = bad_sum ? (sum ^ 8'($urandom_range(255, 1))) : sum;
        foreach (fr[i]) bytes_to_send.push_back(fr[i]);
    endtask

    // axis value leaning on the extremes now and then
    function automatic logic [15:0] pick_axis();
        case ($urandom_range(11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [7:0] pick_type();
        int r;
        r = $urandom_range(99);
        if (r < 28) return TYPE_ACCEL;
        if (r < 54) return TYPE_RATE;
        if (r < 80) return TYPE_ANGLE;
        return 8'($urandom_range(255));
    endfunction

    // mostly good frames, some bad checksums, line noise and cut-off frames
    task automatic queue_random_traffic(input int n_bytes);
        int sent;
        int r;
        int cut;
        sent = 0;
        while (sent < n_bytes) begin
            r = $urandom_range(99);
            if (r < 7) begin
                // noise, while hunting unless a cut-off frame precedes it; not counted
                repeat ($urandom_range(3, 1)) bytes_to_send.push_back(8'($urandom_range(255)));
            end else if (r < 13) begin
                // frame cut short, next header lands inside it
                cut = $urandom_range(8);
                bytes_to_send.push_back(HDR_BYTE);
                bytes_to_send.push_back(pick_type());
                repeat (cut) bytes_to_send.push_back(8'($urandom_range(255)));
                sent += cut + 2;
            end else begin
                push_frame(pick_type(), pick_axis(), pick_axis(), pick_axis(),
                           $urandom_range(99) < 10);
                sent += FRAME_LEN;
            end
        end
    endtask

    // sender pause: nothing new until every queued byte went in and every sample came out
    task automatic wait_all_done();
        @(posedge aclk);
        while (bytes_to_send.size() != 0 || s_valid || samples_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(input int send_idle, input int recv_stall, input int hold,
                             input int n_bytes);
        send_idle_pct  <= send_idle;
        recv_stall_pct <= recv_stall;
        if (hold != 0) hold_left <= hold;
        @(posedge aclk);
        queue_random_traffic(n_bytes);
        wait_all_done();
    endtask

    initial begin : sequencer
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: noise while hunting, the extremes of every kind
        bytes_to_send.push_back(8'h00);
        bytes_to_send.push_back(8'hFF);
        bytes_to_send.push_back(TYPE_ACCEL);
        push_frame(TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'h0000, 1'b0);
        push_frame(TYPE_RATE,  16'h8000, 16'h7FFF, 16'hFFFF, 1'b0);
        push_frame(TYPE_ANGLE, 16'h0001, 16'hFFFF, 16'h7FFF, 1'b0);
        push_frame(TYPE_ANGLE, 16'h8000, 16'h0000, 16'h8001, 1'b0);
        // unknown types give zero values but still count
        push_frame(8'h00, 16'h7FFF, 16'h8000, 16'h1234, 1'b0);
        push_frame(8'hFF, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b0);
        // bad checksum, dropped without a sample, then a good one
        push_frame(TYPE_RATE, 16'h4000, 16'hC000, 16'h0100, 1'b1);
        push_frame(TYPE_RATE, 16'h4000, 16'hC000, 16'h0100, 1'b0);
        // header value inside the frame is ordinary data
        push_frame(HDR_BYTE, 16'h5555, 16'h5555, 16'h5555, 1'b0);
        push_frame(TYPE_ACCEL, 16'h5555, 16'hAAAA, 16'h55AA, 1'b0);
        wait_all_done();

        run_phase(0, 0, 0, 360);
        // long receiver hold-off with the sender pushing flat out
        run_phase(0, 0, HOLD_OFF_LEN, 220);
        run_phase(85, 0, 0, 360);
        run_phase(0, 85, 0, 360);
        run_phase(31, 31, 0, 360);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && samples_due.size() == 0) begin
            $display("tb_imu_frame_parser OK");
        end else begin
            $display("tb_imu_frame_parser NOT OK");
        end
        $finish;
    end

endmodule
